// ----- rtl/core/ssdr_pkg.sv -----
// shared constants and types of the dead-block replacement engine
package ssdr_pkg;

    // default configuration
    localparam int DEF_NUM_SETS      = 2048;
    localparam int DEF_NUM_WAYS      = 16;
    localparam int DEF_SIG_ENTRIES   = 32;
    localparam int DEF_LEADER_COUNT  = 32;
    localparam int DEF_HISTORY_DEPTH = 4;

    // fixed field widths
    localparam int SET_IN_W = 11;
    localparam int WAY_IN_W = 4;
    localparam int ADDR_W   = 64;

    // decay epoch stamp per set, wide enough to outlast one scrub round
    localparam int EPOCH_W = 9;

    // counter codes
    localparam logic [1:0] CNT_MAX  = 2'd3;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_ZERO = 2'd0;

    localparam logic [7:0] DUEL_INIT = 8'd128;
    localparam logic [7:0] DUEL_MAX  = 8'hFF;

    localparam int STREAM_MATCHES = 3;

    typedef enum logic [1:0]
    {
        KIND_FOLLOWER = 2'd0,
        KIND_SRRIP    = 2'd1,
        KIND_BRRIP    = 2'd2
    } leader_kind_t;

endpackage

// ----- rtl/core/ssdr_victim_pick.sv -----
// victim way search over one set row
module ssdr_victim_pick
    import ssdr_pkg::*;
#(
    parameter int NUM_WAYS = DEF_NUM_WAYS,
    parameter int WAY_W    = $clog2(DEF_NUM_WAYS)
)
(
    input  logic [NUM_WAYS-1:0][1:0] rrv,
    input  logic [NUM_WAYS-1:0][1:0] dead,
    output logic [WAY_W-1:0]         way
);

    logic             dead_hit;
    logic [WAY_W-1:0] dead_way;
    logic [3:0]       rrv_hit;
    logic [3:0][WAY_W-1:0] rrv_way;

    // first way per class, scanned from the top so the lowest wins
    always_comb
    begin
        dead_hit = 1'b0;
        dead_way = '0;
        rrv_hit  = '0;
        rrv_way  = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (dead[w] == CNT_MAX)
            begin
                dead_hit = 1'b1;
                dead_way = WAY_W'(w);
            end
            rrv_hit[rrv[w]] = 1'b1;
            rrv_way[rrv[w]] = WAY_W'(w);
        end
    end

    // dead line first, else first line of the highest value
    always_comb
    begin
        priority if (dead_hit)   way = dead_way;
        else if (rrv_hit[3])     way = rrv_way[3];
        else if (rrv_hit[2])     way = rrv_way[2];
        else if (rrv_hit[1])     way = rrv_way[1];
        else                     way = '0;
    end

endmodule

// ----- rtl/core/ship_stream_deadblock_replacement_core.sv -----
// top level of the dead-block replacement engine
//
// Input channel s_*: one word per request. s_tuser carries the op (0 = pick a
// victim in the set, 1 = update after an access); s_tdata carries the access.
// Output channel m_*: exactly one word per request, the victim way (0 for
// updates) and the streaming flag of the set after the request.
// Per-set state lives in two single-port-style synchronous memories, a set
// row (re-reference values, dead counters, signature counters, decay epoch)
// and a history row (delta ring, pointer, streaming flag, last address).
// A victim request is read and its victim pick registered before the result; an update
// goes through read, delta subtract, modify and write back, then one set of the
// background scrubber is read and written to fold in pending dead decay.
// The whole-cache decay is applied lazily by an epoch stamp per set row.
// One request is in flight at a time; the next is accepted in the cycle after
// the result reaches the output register.
// After reset both memories are cleared, one set per cycle, over all NUM_SETS
// sets (2048 by default) while s_tready stays low.
// When the receiver stalls the result waits in the output register; one further
// request may still be accepted and run up to its result, then s_tready stays low.
module ship_stream_deadblock_replacement_core
    import ssdr_pkg::*;
#(
    parameter int NUM_SETS      = DEF_NUM_SETS,
    parameter int NUM_WAYS      = DEF_NUM_WAYS,
    parameter int SIG_ENTRIES   = DEF_SIG_ENTRIES,
    parameter int LEADER_COUNT  = DEF_LEADER_COUNT,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // set_index[10:0], way_index[14:11], pc[78:15], phys_addr[142:79],
    // was_hit[143], victim_valid[144], zero fill
    input  logic [151:0] s_tdata,
    // op[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // victim_way[3:0], set_streaming[4], zero fill
    output logic [7:0]   m_tdata
);

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int WAY_W = $clog2(NUM_WAYS);
    localparam int SIG_W = $clog2(SIG_ENTRIES);
    localparam int HP_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    typedef struct packed
    {
        logic [EPOCH_W-1:0]             epoch;
        logic [NUM_WAYS-1:0][1:0]       rrv;
        logic [NUM_WAYS-1:0][1:0]       dead;
        logic [SIG_ENTRIES-1:0][1:0]    sig;
    } set_row_t;

    typedef struct packed
    {
        logic [HISTORY_DEPTH-1:0][ADDR_W-1:0] ring;
        logic [HP_W-1:0]                      ptr;
        logic                                 flag;
        logic [ADDR_W-1:0]                    prev;
    } hist_row_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DELTA,
        ST_APPLY,
        ST_SCRUB_RD,
        ST_SCRUB_WR,
        ST_RESP
    } state_t;

    // set index modulo the set count, by shifted subtracts
    function automatic logic [SET_W-1:0] reduce_set(input logic [SET_IN_W-1:0] v);
        logic [17:0] r;
        r = 18'(v);
        for (int k = 5; k >= 0; k--)
        begin
            if (r >= (18'(NUM_SETS) << k))
            begin
                r = r - (18'(NUM_SETS) << k);
            end
        end
        return r[SET_W-1:0];
    endfunction

    // way index modulo the way count
    function automatic logic [WAY_W-1:0] reduce_way(input logic [WAY_IN_W-1:0] v);
        logic [8:0] r;
        r = 9'(v);
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= (9'(NUM_WAYS) << k))
            begin
                r = r - (9'(NUM_WAYS) << k);
            end
        end
        return r[WAY_W-1:0];
    endfunction

    state_t              state_reg;
    logic [SET_W-1:0]    ptr_reg;
    logic [SET_W-1:0]    scrub_reg;
    logic                op_reg;
    logic [SET_W-1:0]    set_reg;
    logic [WAY_W-1:0]    way_reg;
    logic [ADDR_W-1:0]   pc_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                hit_reg;
    logic                vv_reg;
    logic [7:0]          duel_reg;
    logic [7:0]          count_reg;
    logic [EPOCH_W-1:0]  epoch_reg;
    hist_row_t           hist_new_reg;
    logic [3:0]          res_way_reg;
    logic                res_flag_reg;
    logic                m_valid_reg;
    logic [3:0]          m_way_reg;
    logic                m_flag_reg;

    // memories
    set_row_t            set_mem [NUM_SETS];
    hist_row_t           hist_mem [NUM_SETS];
    set_row_t            set_rdata_reg;
    hist_row_t           hist_rdata_reg;
    logic                set_re;
    logic                set_we;
    logic [SET_W-1:0]    set_raddr;
    logic [SET_W-1:0]    set_waddr;
    set_row_t            set_wdata;
    logic                hist_re;
    logic                hist_we;
    logic [SET_W-1:0]    hist_waddr;
    hist_row_t           hist_wdata;

    logic                     s_accept;
    logic                     out_free;
    logic [EPOCH_W-1:0]       elapsed;
    logic [1:0]               decay;
    logic [NUM_WAYS-1:0][1:0] dead_eff;
    logic [WAY_W-1:0]         pick_way;
    leader_kind_t             kind;
    logic                     srrip;
    logic [SIG_W-1:0]         sig_idx;
    logic [ADDR_W-1:0]        delta;
    hist_row_t                hist_calc;
    logic [CNT_W-1:0]         match_cnt;
    logic                     flag_new;
    set_row_t                 row_new;
    logic [7:0]               duel_next;
    logic [1:0]               line_rrv;
    logic [1:0]               line_dead;
    logic [1:0]               line_sig;
    logic [7:0]               count_next;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_flag_reg, m_way_reg};

    // memory ports, synchronous read with registered data
    always_ff @(posedge clk)
    begin
        if (set_we)
        begin
            set_mem[set_waddr] <= set_wdata;
        end
        if (set_re)
        begin
            set_rdata_reg <= set_mem[set_raddr];
        end
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (hist_re)
        begin
            hist_rdata_reg <= hist_mem[set_reg];
        end
    end

    // pending decay folded into the dead counters of the row just read
    always_comb
    begin
        elapsed = epoch_reg - set_rdata_reg.epoch;
        decay   = (elapsed >= EPOCH_W'(3)) ? CNT_MAX : elapsed[1:0];
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            dead_eff[w] = (set_rdata_reg.dead[w] > decay) ?
                          (set_rdata_reg.dead[w] - decay) : CNT_ZERO;
        end
    end

    ssdr_victim_pick #(
        .NUM_WAYS (NUM_WAYS),
        .WAY_W    (WAY_W)
    ) u_pick (
        .rrv  (set_rdata_reg.rrv),
        .dead (dead_eff),
        .way  (pick_way)
    );

    // delta tracking on the history row
    always_comb
    begin
        delta = (hist_rdata_reg.prev != '0) ? (addr_reg - hist_rdata_reg.prev) : '0;
        hist_calc = hist_rdata_reg;
        hist_calc.ring[hist_rdata_reg.ptr] = delta;
        hist_calc.ptr  = (hist_rdata_reg.ptr == HP_W'(HISTORY_DEPTH - 1)) ?
                         '0 : (hist_rdata_reg.ptr + 1'b1);
        hist_calc.prev = addr_reg;
        count_next = count_reg + 8'd1;
    end

    // streaming flag from the updated ring
    always_comb
    begin
        match_cnt = '0;
        for (int i = 1; i < HISTORY_DEPTH; i++)
        begin
            if (hist_new_reg.ring[i] == hist_new_reg.ring[0] && hist_new_reg.ring[0] != '0)
            begin
                match_cnt = match_cnt + 1'b1;
            end
        end
        flag_new = (match_cnt >= CNT_W'(STREAM_MATCHES));
    end

    // policy of the set
    always_comb
    begin
        priority if (32'(set_reg) < 32'(LEADER_COUNT))
        begin
            kind = KIND_SRRIP;
        end
        else if (33'(set_reg) + 33'(LEADER_COUNT) >= 33'(NUM_SETS))
        begin
            kind = KIND_BRRIP;
        end
        else
        begin
            kind = KIND_FOLLOWER;
        end
        unique case (kind)
            KIND_SRRIP: srrip = 1'b1;
            KIND_BRRIP: srrip = 1'b0;
            default:    srrip = (duel_reg >= DUEL_INIT);
        endcase
    end

    // line insertion and promotion
    always_comb
    begin
        sig_idx   = pc_reg[2 +: SIG_W] & SIG_W'(SIG_ENTRIES - 1);
        line_rrv  = set_rdata_reg.rrv[way_reg];
        line_dead = dead_eff[way_reg];
        line_sig  = set_rdata_reg.sig[sig_idx];
        duel_next = duel_reg;
        if (hit_reg)
        begin
            line_rrv = CNT_ZERO;
            if (line_dead != CNT_ZERO) line_dead = line_dead - 1'b1;
            if (line_sig != CNT_MAX) line_sig = line_sig + 1'b1;
        end
        else if (flag_new)
        begin
            line_rrv  = CNT_MAX;
            line_dead = CNT_MAX;
        end
        else if (line_dead == CNT_MAX)
        begin
            line_rrv = CNT_MAX;
        end
        else
        begin
            priority if (line_sig == CNT_MAX)
            begin
                line_rrv  = CNT_ZERO;
                line_dead = CNT_ZERO;
            end
            else if (line_sig == CNT_TWO)
            begin
                line_rrv  = CNT_ONE;
                line_dead = CNT_ONE;
            end
            else
            begin
                line_rrv  = srrip ? CNT_TWO : CNT_MAX;
                line_dead = CNT_TWO;
            end
            if (vv_reg)
            begin
                if (line_sig != CNT_ZERO) line_sig = line_sig - 1'b1;
                line_dead = CNT_MAX;
            end
            if (kind == KIND_SRRIP && duel_reg != DUEL_MAX)
            begin
                duel_next = duel_reg + 8'd1;
            end
            else if (kind == KIND_BRRIP && duel_reg != 8'd0)
            begin
                duel_next = duel_reg - 8'd1;
            end
        end
        row_new               = set_rdata_reg;
        row_new.epoch         = epoch_reg;
        row_new.dead          = dead_eff;
        row_new.rrv[way_reg]  = line_rrv;
        row_new.dead[way_reg] = line_dead;
        row_new.sig[sig_idx]  = line_sig;
    end

    // memory control per state
    always_comb
    begin
        set_re     = 1'b0;
        set_we     = 1'b0;
        set_raddr  = set_reg;
        set_waddr  = set_reg;
        set_wdata  = row_new;
        hist_re    = 1'b0;
        hist_we    = 1'b0;
        hist_waddr = set_reg;
        hist_wdata = hist_new_reg;
        hist_wdata.flag = flag_new;
        unique case (state_reg)
            ST_CLEAR:
            begin
                set_we          = 1'b1;
                set_waddr       = ptr_reg;
                set_wdata.epoch = epoch_reg;
                set_wdata.rrv   = {NUM_WAYS{CNT_MAX}};
                set_wdata.dead  = '0;
                set_wdata.sig   = {SIG_ENTRIES{CNT_ONE}};
                hist_we         = 1'b1;
                hist_waddr      = ptr_reg;
                hist_wdata      = '0;
            end
            ST_READ:
            begin
                set_re  = 1'b1;
                hist_re = 1'b1;
            end
            ST_APPLY:
            begin
                set_we  = 1'b1;
                hist_we = 1'b1;
            end
            ST_SCRUB_RD:
            begin
                set_re    = 1'b1;
                set_raddr = scrub_reg;
            end
            ST_SCRUB_WR:
            begin
                set_we          = 1'b1;
                set_waddr       = scrub_reg;
                set_wdata       = set_rdata_reg;
                set_wdata.epoch = epoch_reg;
                set_wdata.dead  = dead_eff;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            ptr_reg      <= '0;
            scrub_reg    <= '0;
            duel_reg     <= DUEL_INIT;
            count_reg    <= '0;
            epoch_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_tready && state_reg != ST_RESP)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == SET_W'(NUM_SETS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        op_reg    <= s_tuser[0];
                        set_reg   <= reduce_set(s_tdata[10:0]);
                        way_reg   <= reduce_way(s_tdata[14:11]);
                        pc_reg    <= s_tdata[78:15];
                        addr_reg  <= s_tdata[142:79];
                        hit_reg   <= s_tdata[143];
                        vv_reg    <= s_tdata[144];
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_DELTA;
                end
                ST_DELTA:
                begin
                    if (!op_reg)
                    begin
                        res_way_reg  <= 4'(pick_way);
                        res_flag_reg <= hist_rdata_reg.flag;
                        state_reg    <= ST_RESP;
                    end
                    else
                    begin
                        hist_new_reg <= hist_calc;
                        count_reg    <= count_next;
                        if (count_next == 8'd0)
                        begin
                            epoch_reg <= epoch_reg + 1'b1;
                        end
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY:
                begin
                    duel_reg     <= duel_next;
                    res_way_reg  <= '0;
                    res_flag_reg <= flag_new;
                    state_reg    <= ST_SCRUB_RD;
                end
                ST_SCRUB_RD:
                begin
                    state_reg <= ST_SCRUB_WR;
                end
                ST_SCRUB_WR:
                begin
                    scrub_reg <= (scrub_reg == SET_W'(NUM_SETS - 1)) ? '0 : (scrub_reg + 1'b1);
                    state_reg <= ST_RESP;
                end
                ST_RESP:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_way_reg   <= res_way_reg;
                        m_flag_reg  <= res_flag_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // no request taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("request accepted while clearing");

    // one request in flight: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_tready)
        else $error("second request accepted while busy");

    // a result is only loaded into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |=> ($stable(m_way_reg) && $stable(m_flag_reg)))
        else $error("stalled result overwritten");

    // the ring pointer read back stays inside the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DELTA) |-> (32'(hist_rdata_reg.ptr) < HISTORY_DEPTH))
        else $error("ring pointer out of range");

endmodule

// ----- tb/ship_stream_deadblock_replacement_core_tb.sv -----
// self-checking testbench for the dead-block replacement engine
`timescale 1ns / 100ps

module ship_stream_deadblock_replacement_core_tb;
    import ssdr_pkg::*;

    localparam int SETS    = DEF_NUM_SETS;
    localparam int WAYS    = DEF_NUM_WAYS;
    localparam int SIGS    = DEF_SIG_ENTRIES;
    localparam int LEADERS = DEF_LEADER_COUNT;
    localparam int HIST    = DEF_HISTORY_DEPTH;
    localparam int RANDOM_WORDS = 650;

    localparam bit OP_VICTIM = 1'b0;
    localparam bit OP_UPDATE = 1'b1;

    typedef struct packed
    {
        bit        op;
        bit [10:0] set_index;
        bit [3:0]  way_index;
        bit [63:0] pc;
        bit [63:0] phys_addr;
        bit        was_hit;
        bit        victim_valid;
    } access_t;

    typedef struct packed
    {
        bit [3:0] victim_way;
        bit       set_streaming;
    } choice_t;

    typedef struct packed
    {
        access_t  acc;
        bit       typed;
        choice_t  want;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;

    // mirror of the engine state
    bit [1:0]  mir_rrv [SETS*WAYS];
    bit [1:0]  mir_dead [SETS*WAYS];
    bit [1:0]  mir_sig [SETS*SIGS];
    bit [63:0] mir_ring [SETS*HIST];
    bit [1:0]  mir_ptr [SETS];
    bit        mir_stream [SETS];
    bit [63:0] mir_prev [SETS];
    bit [7:0]  mir_duel;
    bit [7:0]  mir_updates;

    choice_t pending_choices[$];
    row_t    plan[$];
    int      errors;
    int      words_sent;
    int      words_seen;
    int      stream_hits;
    int      idle_pct;
    int      stall_pct;
    bit [3:0] last_victim;

    ship_stream_deadblock_replacement_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic leader_kind_t kind_of(int s);
        if (s < LEADERS)
            return KIND_SRRIP;
        if (s + LEADERS >= SETS)
            return KIND_BRRIP;
        return KIND_FOLLOWER;
    endfunction

    function automatic void clear_mirror();
        foreach (mir_rrv[i])
        begin
            mir_rrv[i]  = CNT_MAX;
            mir_dead[i] = CNT_ZERO;
        end
        foreach (mir_sig[i])
            mir_sig[i] = CNT_ONE;
        foreach (mir_ring[i])
            mir_ring[i] = '0;
        foreach (mir_ptr[i])
        begin
            mir_ptr[i]    = '0;
            mir_stream[i] = 1'b0;
            mir_prev[i]   = '0;
        end
        mir_duel    = DUEL_INIT;
        mir_updates = '0;
    endfunction

    // computes the engine's answer for one word and advances the mirror
    function automatic choice_t choose_and_update(access_t a);
        choice_t      c;
        int           s;
        int           line;
        int           sig;
        int           base;
        int           match_total;
        bit [63:0]    delta;
        bit           srrip;
        leader_kind_t kind;
        s    = a.set_index % SETS;
        line = s * WAYS + (a.way_index % WAYS);
        sig  = s * SIGS + int'((a.pc >> 2) & (SIGS - 1));
        base = s * HIST;
        kind = kind_of(s);
        c.victim_way = '0;
        if (a.op == OP_VICTIM)
        begin
            // first dead way, else first way with the largest rrv
            c.victim_way = 4'hF;
            for (int w = 0; w < WAYS; w++)
                if (mir_dead[s*WAYS+w] == CNT_MAX && c.victim_way == 4'hF && w != 15)
                    c.victim_way = 4'(w);
            if (!(c.victim_way != 4'hF || mir_dead[s*WAYS+15] == CNT_MAX))
            begin
                bit [1:0] best;
                best = '0;
                c.victim_way = '0;
                for (int w = 0; w < WAYS; w++)
                    if (mir_rrv[s*WAYS+w] > best)
                    begin
                        best = mir_rrv[s*WAYS+w];
                        c.victim_way = 4'(w);
                    end
            end
        end
        else
        begin
            // delta history and stream detection
            delta = (mir_prev[s] != 0) ? a.phys_addr - mir_prev[s] : 64'd0;
            mir_prev[s] = a.phys_addr;
            mir_ring[base + mir_ptr[s]] = delta;
            mir_ptr[s] = mir_ptr[s] + 1'b1;
            match_total = 0;
            for (int i = 1; i < HIST; i++)
                if (mir_ring[base+i] == mir_ring[base] && mir_ring[base] != 0)
                    match_total++;
            mir_stream[s] = (match_total >= STREAM_MATCHES);
            // periodic decay of every dead counter
            mir_updates = mir_updates + 1'b1;
            if (mir_updates == 0)
                foreach (mir_dead[i])
                    if (mir_dead[i] != 0)
                        mir_dead[i] = mir_dead[i] - 1'b1;
            srrip = (kind == KIND_SRRIP) ||
                    (kind == KIND_FOLLOWER && mir_duel >= DUEL_INIT);
            if (a.was_hit)
            begin
                mir_rrv[line] = CNT_ZERO;
                if (mir_dead[line] != 0)
                    mir_dead[line] = mir_dead[line] - 1'b1;
                if (mir_sig[sig] < CNT_MAX)
                    mir_sig[sig] = mir_sig[sig] + 1'b1;
            end
            else if (mir_stream[s])
            begin
                mir_rrv[line]  = CNT_MAX;
                mir_dead[line] = CNT_MAX;
            end
            else if (mir_dead[line] == CNT_MAX)
                mir_rrv[line] = CNT_MAX;
            else
            begin
                // insertion by signature strength
                if (mir_sig[sig] == CNT_MAX)
                begin
                    mir_rrv[line]  = CNT_ZERO;
                    mir_dead[line] = CNT_ZERO;
                end
                else if (mir_sig[sig] == CNT_TWO)
                begin
                    mir_rrv[line]  = CNT_ONE;
                    mir_dead[line] = CNT_ONE;
                end
                else
                begin
                    mir_rrv[line]  = srrip ? CNT_TWO : CNT_MAX;
                    mir_dead[line] = CNT_TWO;
                end
                if (a.victim_valid)
                begin
                    if (mir_sig[sig] != 0)
                        mir_sig[sig] = mir_sig[sig] - 1'b1;
                    mir_dead[line] = CNT_MAX;
                end
                if (kind == KIND_SRRIP && mir_duel != DUEL_MAX)
                    mir_duel = mir_duel + 1'b1;
                else if (kind == KIND_BRRIP && mir_duel != 0)
                    mir_duel = mir_duel - 1'b1;
            end
        end
        c.set_streaming = mir_stream[s];
        return c;
    endfunction

    // drives one word, waits for acceptance and records what should come back
    task automatic send_word(access_t a, bit typed, choice_t want);
        choice_t c;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= a.op;
        s_tdata  <= {7'b0, a.victim_valid, a.was_hit, a.phys_addr, a.pc,
                     a.way_index, a.set_index};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        c = choose_and_update(a);
        if (a.op == OP_VICTIM)
            last_victim = c.victim_way;
        stream_hits += c.set_streaming;
        pending_choices.push_back(typed ? want : c);
        words_sent++;
    endtask

    function automatic access_t mk(bit op, int s, int w, bit [63:0] pc, bit [63:0] addr,
                                   bit hit, bit vv);
        access_t a;
        a.op = op;
        a.set_index = 11'(s);
        a.way_index = 4'(w);
        a.pc = pc;
        a.phys_addr = addr;
        a.was_hit = hit;
        a.victim_valid = vv;
        return a;
    endfunction

    function automatic void add_row(access_t a, bit typed, bit [3:0] way, bit strm);
        row_t r;
        r.acc = a;
        r.typed = typed;
        r.want.victim_way = way;
        r.want.set_streaming = strm;
        plan.push_back(r);
    endfunction

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly a small pool of leader and follower sets so their state builds up
    function automatic int pick_set();
        int pool[12] = '{0, 1, 2, 3, 100, 101, 102, 103, 2044, 2045, 2046, 2047};
        if ($urandom_range(9) < 7)
            return pool[$urandom_range(11)];
        return $urandom_range(SETS - 1);
    endfunction

    // result checker
    always @(posedge clk)
    begin
        choice_t exp_c;
        if (rst_n && m_tvalid && m_tready)
        begin
            words_seen++;
            if (pending_choices.size() == 0)
            begin
                $error("word 0x%0h arrived with nothing expected", m_tdata);
                errors++;
            end
            else
            begin
                exp_c = pending_choices.pop_front();
                if (m_tdata[3:0] != exp_c.victim_way)
                begin
                    $error("victim_way: expected %0d, got %0d", exp_c.victim_way,
                           m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[4] != exp_c.set_streaming)
                begin
                    $error("set_streaming: expected %0d, got %0d", exp_c.set_streaming,
                           m_tdata[4]);
                    errors++;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // run limit
    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus
    initial
    begin
        access_t a;
        int kind;
        int s;
        int n;
        bit [63:0] addr;
        bit [63:0] stride;
        bit [63:0] pc;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        errors = 0;
        words_sent = 0;
        words_seen = 0;
        stream_hits = 0;
        idle_pct = 0;
        stall_pct = 0;
        last_victim = '0;
        clear_mirror();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset state, extremes, hit, fills of every kind, streaming
        add_row(mk(OP_VICTIM, 0, 0, 0, 0, 0, 0), 1, 4'd0, 1'b0);
        add_row(mk(OP_VICTIM, 2047, 15, '1, '1, 1, 1), 1, 4'd0, 1'b0);
        add_row(mk(OP_UPDATE, 0, 15, '1, '1, 1, 0), 0, 0, 0);
        add_row(mk(OP_UPDATE, 2047, 0, 0, 1, 0, 1), 0, 0, 0);
        add_row(mk(OP_VICTIM, 2047, 0, 0, 0, 0, 0), 1, 4'd0, 1'b0);
        add_row(mk(OP_UPDATE, 2047, 0, 0, 2, 0, 0), 0, 0, 0);
        add_row(mk(OP_UPDATE, 100, 3, 64'h40, 64'h8000, 0, 0), 0, 0, 0);
        for (int i = 0; i < 5; i++)
            add_row(mk(OP_UPDATE, 5, i, 64'h10, 64'h1000 + 64'h40 * i, 0, 0), 0, 0, 0);
        add_row(mk(OP_UPDATE, 5, 9, 64'h10, 64'h1140, 0, 1), 0, 0, 0);
        add_row(mk(OP_VICTIM, 5, 0, 0, 0, 0, 0), 0, 0, 0);
        add_row(mk(OP_UPDATE, 7, 1, 64'h4, 64'h2000, 1, 0), 0, 0, 0);
        add_row(mk(OP_UPDATE, 7, 1, 64'h4, 64'h2000, 1, 0), 0, 0, 0);
        add_row(mk(OP_UPDATE, 7, 2, 64'h4, 64'h3000, 0, 1), 0, 0, 0);
        add_row(mk(OP_UPDATE, 8, 4, 64'h7C, 64'h4000, 1, 0), 0, 0, 0);
        add_row(mk(OP_UPDATE, 8, 5, 64'h7C, 64'h5000, 0, 0), 0, 0, 0);
        add_row(mk(OP_VICTIM, 8, 0, 0, 0, 0, 0), 0, 0, 0);
        add_row(mk(OP_UPDATE, 1000, 15, 64'hFFFF_0000_FFFF_0000,
                   64'h0000_FFFF_0000_FFFF, 0, 1), 0, 0, 0);
        add_row(mk(OP_VICTIM, 1000, 0, 0, 0, 0, 0), 0, 0, 0);
        foreach (plan[i])
            send_word(plan[i].acc, plan[i].typed, plan[i].want);

        // random: four idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            n = 0;
            while (n < RANDOM_WORDS / 4)
            begin
                kind = $urandom_range(9);
                s = pick_set();
                pc = rand64();
                if (kind < 3)
                begin
                    // strided run, usually long enough to turn streaming on
                    addr = rand64();
                    stride = $urandom_range(3) == 0 ? rand64() : 64'($urandom_range(8)) << 6;
                    for (int i = $urandom_range(8, 4); i > 0; i--)
                    begin
                        send_word(mk(OP_UPDATE, s, $urandom_range(15), pc, addr,
                                     $urandom_range(3) == 0, 1'($urandom_range(1))), 0, '0);
                        addr += stride;
                        n++;
                    end
                end
                else if (kind < 6)
                begin
                    // victim request followed by the fill of that way
                    send_word(mk(OP_VICTIM, s, $urandom_range(15), rand64(), rand64(),
                                 1'($urandom_range(1)), 1'($urandom_range(1))), 0, '0);
                    send_word(mk(OP_UPDATE, s, last_victim, pc, rand64(), 0,
                                 $urandom_range(3) != 0), 0, '0);
                    n += 2;
                end
                else if (kind < 9)
                begin
                    // hits with a few recurring signatures
                    send_word(mk(OP_UPDATE, s, $urandom_range(15),
                                 64'($urandom_range(3)) << 2, rand64(), 1,
                                 1'($urandom_range(1))),
                              0, '0);
                    n++;
                end
                else
                begin
                    a = {1'($urandom_range(1)), 11'($urandom), 4'($urandom), rand64(),
                         rand64(), 1'($urandom), 1'($urandom)};
                    send_word(a, 0, '0);
                    n++;
                end
            end
        end
        s_tvalid <= 1'b0;
        stall_pct = 0;

        while (pending_choices.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("%0d words sent and %0d results checked over four idling phases,",
                 words_sent, words_seen);
        $display("%0d results reported a streaming set", stream_hits);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- ship_stream_deadblock_replacement_core.f -----
rtl/core/ssdr_pkg.sv
rtl/core/ssdr_victim_pick.sv
rtl/core/ship_stream_deadblock_replacement_core.sv
tb/ship_stream_deadblock_replacement_core_tb.sv
